@@ src/wrms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrms_pkg
// Shared types and constants for the windowed RMS block.
// ----------------------------------------------------------------------------
package wrms_pkg;

	localparam int MAX_WINDOW   = 256;
	localparam int SLOT_W       = $clog2(MAX_WINDOW);
	localparam int WIN_W        = 9;
	localparam int THR_W        = 16;
	localparam int SAMPLE_W     = 10;
	localparam int MAG_W        = 10;
	localparam int RMS_W        = 17;
	localparam int S1_W         = MAG_W + SLOT_W;
	localparam int S2_W         = 2 * MAG_W + SLOT_W - 1;
	localparam int PROD_W       = S1_W + S2_W;
	localparam int NUM_W        = WIN_W + S2_W;
	localparam int DEN_W        = 2 * WIN_W - 1;
	localparam int FRAC_SHIFT   = 16;
	localparam int DIVD_W       = NUM_W + FRAC_SHIFT;
	localparam int REM_W        = DEN_W + 1;
	localparam int SQRT_STEPS   = DIVD_W / 2;
	localparam int CNT_W        = 9;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;

	localparam logic [SAMPLE_W-1:0] ADC_MIDPOINT    = 10'd512;
	localparam logic [WIN_W-1:0]    WINDOW_RESET    = 9'd200;
	localparam logic [THR_W-1:0]    THRESHOLD_RESET = 16'd77;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'b1;

	localparam logic CMD_PUT = 1'b0;
	localparam logic CMD_GET = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MUL_NS2,
		ST_MUL_S1S1,
		ST_MUL_NN,
		ST_DIV,
		ST_SQRT,
		ST_DONE
	} wrms_state_t;

endpackage

@@ src/wrms_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrms channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface wrms_in_if import wrms_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                cmd;
	logic [SAMPLE_W-1:0] raw_sample;
	modport source (output valid, cmd, raw_sample, input ready);
	modport sink   (input valid, cmd, raw_sample, output ready);
endinterface

interface wrms_out_if import wrms_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RMS_W-1:0] rms_value;
	modport source (output valid, rms_value, input ready);
	modport sink   (input valid, rms_value, output ready);
endinterface

interface wrms_cfg_if import wrms_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ src/windowed_rms_with_hysteresis_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_rms_with_hysteresis_unit
// Sliding-window standard deviation of rectified ADC samples, with a held
// output that only moves by at least a set threshold.
// ----------------------------------------------------------------------------
// Usage:
//  din carries items: cmd 0 stores |raw_sample-512| in the ring, cmd 1
//  requests the RMS. Only a request gives an item on dout (held RMS, Q8).
//  cfg writes window_len (index 0) and hold_threshold (index 1); the user must write only when idle (not enforced).
// Request sequence:
//  A request sums the window over the ring RAM read port, forms n*S2, S1*S1
//  and n*n on the shared multiplier, runs restoring division (one load, 52
//  steps) and the square root on the shared subtractor, then loads the
//  result. din is not ready meanwhile.
// Reset:
//  Clears the ring (per-entry valid flags), write slot, held value and
//  registers to their defaults. No clearing pass is needed.
// Stalls:
//  A result sits in the output register; a new item is taken while it
//  waits, but the next result holds in its last step until dout drains.
// ----------------------------------------------------------------------------
module windowed_rms_with_hysteresis_unit import wrms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	wrms_in_if.sink     din,
	wrms_out_if.source  dout,
	wrms_cfg_if.sink    cfg
);
	wrms_state_t state_q, state_d;

	logic [WIN_W-1:0]      win_q;
	logic [THR_W-1:0]      thr_q;
	logic [SLOT_W-1:0]     wslot_q;
	logic [RMS_W-1:0]      held_q;
	logic [MAX_WINDOW-1:0] vld_q;
	logic                  out_valid_q;
	logic [RMS_W-1:0]      out_data_q;

	logic [CNT_W-1:0]      cnt_q;
	logic                  pend_s1;
	logic                  vld_s1;
	logic [S1_W-1:0]       s1_q;
	logic [S2_W-1:0]       s2_q;
	logic [PROD_W-1:0]     prod_q;
	logic [NUM_W-1:0]      ns2_q;
	logic [NUM_W-1:0]      num_q;
	logic [DEN_W-1:0]      den_q;
	logic [REM_W-1:0]      rem_q;
	logic [DIVD_W-1:0]     dq_q;
	logic [DIVD_W-1:0]     res_q;

	logic [WIN_W-1:0]      n_eff;
	logic [SLOT_W-1:0]     put_slot;
	logic [SLOT_W:0]       put_next;
	logic [MAG_W-1:0]      mag;
	logic                  put_acc;
	logic                  rd_en;
	logic [MAG_W-1:0]      rd_data;
	logic [MAG_W-1:0]      rd_val;

	logic [S2_W-1:0]       mul_a;
	logic [S1_W-1:0]       mul_b;
	logic [DIVD_W:0]       sub_a;
	logic [DIVD_W:0]       sub_b;
	logic [DIVD_W+1:0]     sub_r;
	logic                  sub_ge;
	logic [DIVD_W-1:0]     sq_bit;
	logic [REM_W-1:0]      rem_sh;

	logic [RMS_W-1:0]      rms_sat;
	logic [RMS_W-1:0]      rms_diff;
	logic                  out_free;

	always_comb begin
		if (win_q == '0) begin
			n_eff = WIN_W'(1);
		end else if (win_q > WIN_W'(MAX_WINDOW)) begin
			n_eff = WIN_W'(MAX_WINDOW);
		end else begin
			n_eff = win_q;
		end
	end

	assign put_slot = ({1'b0, wslot_q} >= n_eff) ? '0 : wslot_q;
	assign put_next = {1'b0, put_slot} + 1'b1;
	assign mag = (din.raw_sample >= ADC_MIDPOINT) ? (din.raw_sample - ADC_MIDPOINT)
		: (ADC_MIDPOINT - din.raw_sample);
	assign put_acc = din.valid && din.ready && (din.cmd == CMD_PUT);

	assign din.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign dout.valid = out_valid_q;
	assign dout.rms_value = out_data_q;
	assign out_free = !out_valid_q || dout.ready;

	assign rd_en = (state_q == ST_SUM) && (cnt_q < n_eff);

	wrms_ram #(.WIDTH(MAG_W), .DEPTH(MAX_WINDOW)) u_ring (
		.clk   (clk),
		.we    (put_acc),
		.waddr (put_slot),
		.wdata (mag),
		.re    (rd_en),
		.raddr (cnt_q[SLOT_W-1:0]),
		.rdata (rd_data)
	);

	assign rd_val = vld_s1 ? rd_data : '0;

	// shared multiplier operands
	always_comb begin
		case (state_q)
			ST_MUL_NS2:  begin
				mul_a = s2_q;
				mul_b = S1_W'(n_eff);
			end
			ST_MUL_S1S1: begin
				mul_a = S2_W'(s1_q);
				mul_b = s1_q;
			end
			default:     begin
				mul_a = S2_W'(n_eff);
				mul_b = S1_W'(n_eff);
			end
		endcase
	end

	// shared subtractor: division remainder or square root trial
	assign rem_sh = {rem_q[REM_W-2:0], dq_q[DIVD_W-1]};
	assign sq_bit = DIVD_W'(1) << {cnt_q[4:0], 1'b0};
	always_comb begin
		if (state_q == ST_DIV) begin
			sub_a = (DIVD_W+1)'(rem_sh);
			sub_b = (DIVD_W+1)'(den_q);
		end else begin
			sub_a = {1'b0, dq_q};
			sub_b = {1'b0, res_q} + {1'b0, sq_bit};
		end
	end
	assign sub_r  = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge = !sub_r[DIVD_W+1];

	assign rms_sat  = (res_q > DIVD_W'({RMS_W{1'b1}})) ? {RMS_W{1'b1}} : res_q[RMS_W-1:0];
	assign rms_diff = (rms_sat > held_q) ? (rms_sat - held_q) : (held_q - rms_sat);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (din.valid && din.cmd == CMD_GET) state_d = ST_SUM;
			ST_SUM:      if (!rd_en && !pend_s1) state_d = ST_MUL_NS2;
			ST_MUL_NS2:  state_d = ST_MUL_S1S1;
			ST_MUL_S1S1: state_d = ST_MUL_NN;
			ST_MUL_NN:   state_d = ST_DIV;
			ST_DIV:      if (cnt_q == CNT_W'(DIVD_W)) state_d = ST_SQRT;
			ST_SQRT:     if (cnt_q == '0) state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= WINDOW_RESET;
			thr_q       <= THRESHOLD_RESET;
			wslot_q     <= '0;
			held_q      <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
			pend_s1     <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_WINDOW_LEN: win_q <= cfg.data[WIN_W-1:0];
					REG_THRESHOLD:  thr_q <= cfg.data;
					default:        ;
				endcase
			end
			if (put_acc) begin
				vld_q[put_slot] <= 1'b1;
				wslot_q <= (put_next >= n_eff) ? '0 : put_next[SLOT_W-1:0];
			end
			if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			pend_s1 <= rd_en;
			case (state_q)
				ST_IDLE:   cnt_q <= '0;
				ST_SUM:    if (rd_en) cnt_q <= cnt_q + 1'b1;
				ST_MUL_NN: cnt_q <= '0;
				ST_DIV:    begin
					if (cnt_q == CNT_W'(DIVD_W)) begin
						cnt_q <= CNT_W'(SQRT_STEPS - 1);
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQRT:   cnt_q <= cnt_q - 1'b1;
				ST_DONE:   begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (rms_diff >= RMS_W'(thr_q)) begin
							held_q <= rms_sat;
						end
					end
				end
				default:   ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		vld_s1 <= vld_q[cnt_q[SLOT_W-1:0]];
		prod_q <= mul_a * mul_b;
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= (rms_diff >= RMS_W'(thr_q)) ? rms_sat : held_q;
		end
		case (state_q)
			ST_IDLE:     begin
				s1_q <= '0;
				s2_q <= '0;
			end
			ST_SUM:      begin
				if (pend_s1) begin
					s1_q <= s1_q + S1_W'(rd_val);
					s2_q <= s2_q + S2_W'(rd_val) * S2_W'(rd_val);
				end
			end
			ST_MUL_S1S1: ns2_q <= prod_q[NUM_W-1:0];
			ST_MUL_NN:   num_q <= ns2_q - prod_q[NUM_W-1:0];
			ST_DIV:      begin
				if (cnt_q == '0) begin
					den_q <= prod_q[DEN_W-1:0];
					dq_q  <= {num_q, {FRAC_SHIFT{1'b0}}};
					rem_q <= '0;
				end else begin
					// one quotient bit per cycle
					dq_q  <= {dq_q[DIVD_W-2:0], sub_ge};
					rem_q <= sub_ge ? sub_r[REM_W-1:0] : rem_sh;
					if (cnt_q == CNT_W'(DIVD_W)) begin
						res_q <= '0;
					end
				end
			end
			ST_SQRT:     begin
				if (sub_ge) begin
					dq_q  <= sub_r[DIVD_W-1:0];
					res_q <= (res_q >> 1) + sq_bit;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			default:     ;
		endcase
	end
endmodule

@@ src/wrms_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wrms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ sim/tb_windowed_rms_with_hysteresis_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_rms_with_hysteresis_unit
// Drives sample stores and RMS requests through the valid/ready channels and
// compares each held RMS result against a standard-deviation predictor with
// hysteresis, across several window lengths and thresholds.
// ----------------------------------------------------------------------------
module tb_windowed_rms_with_hysteresis_unit;
	import wrms_pkg::*;

	localparam int WDOG_LIMIT = 20000;

	typedef struct packed {
		logic                cmd;
		logic [SAMPLE_W-1:0] raw;
	} item_t;

	logic clk = 1'b0;
	logic arst_n;

	wrms_in_if  din ();
	wrms_out_if dout ();
	wrms_cfg_if cfg ();

	windowed_rms_with_hysteresis_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout),
		.cfg    (cfg)
	);

	// predictor state
	logic [MAG_W-1:0] ring_mag [MAX_WINDOW];
	int unsigned      slot_next;
	logic [RMS_W-1:0] rms_held;
	logic [WIN_W-1:0] win_reg;
	logic [THR_W-1:0] thr_reg;

	item_t            pending_items [$];
	logic [RMS_W-1:0] rms_expected [$];
	int               mismatches;
	int               watchdog;
	int               stall_hold;
	bit               timed_out;
	bit               stim_done;
	bit               out_busy;
	bit               long_done;

	always #4 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic predict_item(item_t it);
		int unsigned     n;
		int unsigned     s;
		longint unsigned s1, s2, num, rms, diff;
		n = (win_reg == 0) ? 1 : ((win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg);
		if (it.cmd == CMD_PUT) begin
			s = (slot_next >= n) ? 0 : slot_next;
			ring_mag[s] = (it.raw >= ADC_MIDPOINT) ? it.raw - ADC_MIDPOINT
				: ADC_MIDPOINT - it.raw;
			s++;
			slot_next = (s >= n) ? 0 : s;
		end else begin
			s1 = 0;
			s2 = 0;
			for (int i = 0; i < n; i++) begin
				s1 += ring_mag[i];
				s2 += ring_mag[i] * ring_mag[i];
			end
			num = n * s2 - s1 * s1;
			rms = int_sqrt((num << FRAC_SHIFT) / (n * n));
			if (rms > 64'h1FFFF) rms = 64'h1FFFF;
			diff = (rms > rms_held) ? rms - rms_held : rms_held - rms;
			if (diff >= thr_reg) rms_held = rms[RMS_W-1:0];
			rms_expected.push_back(rms_held);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din.valid      <= 1'b0;
			din.cmd        <= CMD_PUT;
			din.raw_sample <= '0;
			for (int i = 0; i < MAX_WINDOW; i++) ring_mag[i] = '0;
			slot_next = 0;
			rms_held  = '0;
		end else if (!din.valid || din.ready) begin
			if (din.valid) predict_item('{cmd: din.cmd, raw: din.raw_sample});
			if (pending_items.size() > 0 && $urandom_range(0, 9) < 8) begin
				item_t it;
				it = pending_items.pop_front();
				din.valid      <= 1'b1;
				din.cmd        <= it.cmd;
				din.raw_sample <= it.raw;
			end else begin
				din.valid <= 1'b0;
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout.ready <= 1'b0;
			stall_hold <= 0;
			long_done  <= 1'b0;
		end else begin
			if (dout.valid && dout.ready) begin
				if (rms_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result rms_value=%0d", dout.rms_value);
				end else begin
					logic [RMS_W-1:0] exp_rms;
					exp_rms = rms_expected.pop_front();
					if (dout.rms_value !== exp_rms) begin
						mismatches++;
						if (mismatches <= 10)
							$display("rms_value mismatch: expected %0d, got %0d",
								exp_rms, dout.rms_value);
					end
				end
			end
			if (stall_hold > 0) begin
				stall_hold <= stall_hold - 1;
				dout.ready <= 1'b0;
			end else if (out_busy && !long_done) begin
				// long hold-off while the sender keeps offering
				stall_hold <= 3000;
				long_done  <= 1'b1;
				dout.ready <= 1'b0;
			end else begin
				case ($urandom_range(0, 19))
					0:       stall_hold <= $urandom_range(20, 400);
					1, 2, 3: stall_hold <= $urandom_range(1, 4);
					default: ;
				endcase
				dout.ready <= (stim_done || $urandom_range(0, 3) != 0);
			end
		end
	end

	// watchdog on accepted handshakes
	always @(posedge clk) begin
		if (!arst_n || (din.valid && din.ready) || (dout.valid && dout.ready)
				|| (cfg.valid && cfg.ready)) begin
			watchdog <= 0;
		end else begin
			watchdog <= watchdog + 1;
			if (watchdog >= WDOG_LIMIT && !timed_out) begin
				timed_out = 1'b1;
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == REG_WINDOW_LEN) win_reg = val[WIN_W-1:0];
		else thr_reg = val[THR_W-1:0];
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || din.valid || rms_expected.size() > 0)
			@(posedge clk);
		// stores give no result, so allow the longest request time too
		repeat (MAX_WINDOW + 100) @(posedge clk);
	endtask

	task automatic add_put(logic [SAMPLE_W-1:0] raw);
		pending_items.push_back('{cmd: CMD_PUT, raw: raw});
	endtask

	task automatic add_get();
		pending_items.push_back('{cmd: CMD_GET, raw: SAMPLE_W'($urandom)});
	endtask

	// random phase: mostly bursts of samples then a request
	task automatic add_random(int count);
		int k;
		k = 0;
		while (k < count) begin
			case ($urandom_range(0, 3))
				0:       add_put(SAMPLE_W'($urandom));
				1:       add_put($urandom_range(0, 1) ? 10'd1023 : 10'd0);
				default: add_put(SAMPLE_W'(512 + $urandom_range(0, 60) - 30));
			endcase
			k++;
			if ($urandom_range(0, 5) == 0) begin
				add_get();
				k++;
			end
		end
	endtask

	initial begin
		logic [WIN_W-1:0] windows [6];
		logic [THR_W-1:0] thresholds [6];
		windows    = '{9'd1, 9'd256, 9'd0, 9'd3, 9'd300, 9'd37};
		thresholds = '{16'd0, 16'd65535, 16'd1, 16'd77, 16'd0, 16'd300};
		arst_n     = 1'b0;
		cfg.valid  = 1'b0;
		cfg.index  = REG_WINDOW_LEN;
		cfg.data   = '0;
		win_reg    = WINDOW_RESET;
		thr_reg    = THRESHOLD_RESET;
		stim_done  = 1'b0;
		out_busy   = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset window, extremes, zero-ring request
		add_get();
		add_put(10'd0);
		add_put(10'd1023);
		add_put(10'd512);
		add_put(10'd511);
		add_put(10'd513);
		add_get();
		wait_idle();
		write_reg(REG_WINDOW_LEN, 16'd4);
		write_reg(REG_THRESHOLD, 16'd0);
		add_put(10'd0);
		add_put(10'd1023);
		add_put(10'd0);
		add_put(10'd1023);
		add_get();
		add_put(10'd512);
		add_get();
		// shrink window
		wait_idle();
		write_reg(REG_WINDOW_LEN, 16'd2);
		add_put(10'd100);
		add_get();
		wait_idle();
		write_reg(REG_WINDOW_LEN, 16'h1FF);
		add_put(10'h2AA);
		add_put(10'h155);
		add_get();

		// output stall long enough that the input backs up
		wait_idle();
		write_reg(REG_WINDOW_LEN, 16'd5);
		out_busy = 1'b1;
		add_random(40);
		wait_idle();
		out_busy = 1'b0;

		foreach (windows[p]) begin
			wait_idle();
			write_reg(REG_WINDOW_LEN, 16'(windows[p]));
			write_reg(REG_THRESHOLD, thresholds[p]);
			add_random(190);
		end
		wait_idle();
		stim_done = 1'b1;
		repeat (MAX_WINDOW + 100) @(posedge clk);
		if (mismatches == 0 && rms_expected.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/wrms_pkg.sv
src/wrms_if.sv
src/wrms_ram.sv
src/windowed_rms_with_hysteresis_unit.sv
sim/tb_windowed_rms_with_hysteresis_unit.sv
